/* src/afwd_pkg.sv */
// afwd_pkg: item types and key mixing constants for the word decrypt unit
// no dependencies; used by every module of the block
package afwd_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned SeedW = 32;
  localparam int unsigned HalfW = 32;
  localparam int unsigned LaneW = 16;
  localparam int unsigned Lanes = WordW / LaneW;

  // key mixing constants
  localparam logic [HalfW-1:0] MixC1 = 32'h5D58_8B65;
  localparam logic [HalfW-1:0] MixC2 = 32'hCA62_C1D6;
  localparam logic [HalfW-1:0] MixC3 = 32'h8F1B_BCDC;
  localparam logic [HalfW-1:0] MixC4 = 32'h6C07_8965;

  typedef struct packed {
    logic [WordW-1:0] cipher_word;
    logic             first_word;
    logic [SeedW-1:0] entry_seed;
    logic             last_word;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] plain_word;
    logic             last_out;
  } out_item_t;

  // result of the combinational decrypt path
  typedef struct packed {
    logic [WordW-1:0] plain;
    logic [WordW-1:0] key_next;
  } xf_res_t;

endpackage

/* src/afwd_key_derive.sv */
// afwd_key_derive: derives a fresh 64-bit key from a 32-bit entry seed
// depends on afwd_pkg for widths and mixing constants
module afwd_key_derive (
  input  logic [afwd_pkg::SeedW-1:0] seed,
  output logic [afwd_pkg::WordW-1:0] key
);

  logic [afwd_pkg::HalfW-1:0] lo0, hi0, lo1, hi1;

  // chained add / xor mixing, low half then high half
  always_comb begin
    lo0 = (seed + afwd_pkg::MixC1) ^ seed;
    hi0 = (seed + afwd_pkg::MixC2) ^ lo0;
    lo1 = (lo0 + afwd_pkg::MixC3) ^ hi0;
    hi1 = (hi0 + afwd_pkg::MixC4) ^ lo1;
    key = {hi1, lo1};
  end

endmodule

/* src/afwd_xor_feedback.sv */
// afwd_xor_feedback: xors a cipher word with the key and folds the plain
// word back into the key lane by lane; depends on afwd_pkg
module afwd_xor_feedback (
  input  logic [afwd_pkg::WordW-1:0] cipher,
  input  logic [afwd_pkg::WordW-1:0] key,
  output afwd_pkg::xf_res_t          res
);

  logic [afwd_pkg::WordW-1:0] plain;
  logic [afwd_pkg::WordW-1:0] key_next;

  assign plain = cipher ^ key;

  // independent 16-bit lane adds, each wrapping
  always_comb begin
    for (int k = 0; k < afwd_pkg::Lanes; k++) begin
      key_next[k*afwd_pkg::LaneW +: afwd_pkg::LaneW] =
        key[k*afwd_pkg::LaneW +: afwd_pkg::LaneW] +
        plain[k*afwd_pkg::LaneW +: afwd_pkg::LaneW];
    end
  end

  assign res.plain    = plain;
  assign res.key_next = key_next;

endmodule

/* src/additive_feedback_word_decrypt_unit.sv */
// additive_feedback_word_decrypt_unit: top level, input register, key
// register and result register; depends on afwd_pkg, afwd_key_derive, afwd_xor_feedback
//
// Takes one cipher word per clock and returns one plain word per clock
// while the result side does not stall; each word passes the input register,
// then the result register. The running key lives in a single register that is updated in
// the same cycle a word moves from the input register into the result
// register, so consecutive words of an entry follow each other with no
// gap. A word flagged first_word uses a key freshly derived from its
// entry_seed; other words use the key left by the previous word. After
// reset the key is zero. Backpressure on the result side holds both
// registers; the input side still takes a word while a result waits as
// long as the input register is free.
module additive_feedback_word_decrypt_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  afwd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output afwd_pkg::out_item_t out_data
);

  afwd_pkg::in_item_t         s1_r;
  logic                       s1_vld_r, s1_vld_nxt;
  logic                       out_vld_r, out_vld_nxt;
  afwd_pkg::out_item_t        out_r;
  logic [afwd_pkg::WordW-1:0] key_r, key_nxt;
  logic [afwd_pkg::WordW-1:0] derived_key;
  logic [afwd_pkg::WordW-1:0] use_key;
  afwd_pkg::xf_res_t          xf;
  logic                       adv;

  // handshake control
  assign adv        = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !s1_vld_r || adv;
  assign s1_vld_nxt = in_ready ? in_valid : s1_vld_r;
  assign out_vld_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  // key selection and decrypt path
  afwd_key_derive u_derive (
    .seed (s1_r.entry_seed),
    .key  (derived_key)
  );

  assign use_key = s1_r.first_word ? derived_key : key_r;

  afwd_xor_feedback u_xf (
    .cipher (s1_r.cipher_word),
    .key    (use_key),
    .res    (xf)
  );

  assign key_nxt = adv ? xf.key_next : key_r;

  // control and key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      key_r     <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      key_r     <= key_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (adv) begin
      out_r.plain_word <= xf.plain;
      out_r.last_out   <= s1_r.last_word;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // a held input word is never overwritten while the result side stalls
  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_ready) |-> !in_ready)
    else $error("input register overwritten during stall");

  // the key only moves when a word advances
  a_key_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(key_r))
    else $error("key changed without a word advancing");

  // a word that advances always yields a result next cycle
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced word produced no result");

endmodule
